// ===== rtl/angular_occlusion_range_set_assert.svh =====
// Assertion macros for the angular occlusion range set.
// Needs i_clk and i_rst_n in the scope where the macros are used.
`ifndef ANGULAR_OCCLUSION_RANGE_SET_ASSERT_SVH
`define ANGULAR_OCCLUSION_RANGE_SET_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define AORS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define AORS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AORS_ASSERT_IMPL(label, ante, cons)
`define AORS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/aors_pkg.sv =====
// Package for the angular occlusion range set.
// Holds the operation codes and the top angle; depends on nothing.
package aors_pkg;
    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_QUERY  = 2'd1,
        MODE_MARK   = 2'd2,
        MODE_INVERT = 2'd3
    } t_mode;

    localparam logic [31:0] ANGLE_TOP = 32'hFFFF_FFFF;
endpackage

// ===== rtl/angular_occlusion_range_set.sv =====
// Angular occlusion range set: a sorted list of disjoint angle ranges in two memories.
// Depends on aors_pkg and angular_occlusion_range_set_assert.svh.
//
// One item at a time runs through a sequencer that reads one table entry at a time
// (address, then use of the registered read data in the following check state).
// Clear empties the table; query and mark scan the entries in order, twice for a
// wrapped range, and mark also shifts entries up or down; invert walks the ranges
// stored before the item. Every read goes through the single read port of the start
// and end memories. A new item is taken while the previous result still waits at
// the output register.
module angular_occlusion_range_set #(
    parameter int MAX_RANGES = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  aors_pkg::t_mode                     i_mode,
    input  logic [31:0]                         i_start_angle,
    input  logic [31:0]                         i_end_angle,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_covered,
    output logic                                o_table_full,
    output logic [$clog2(MAX_RANGES+1)-1:0]     o_range_count
);
    import aors_pkg::*;
    `include "angular_occlusion_range_set_assert.svh"

    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam logic [CW-1:0] MAXC = CW'(MAX_RANGES);
    localparam logic [CW-1:0] ONE = CW'(1);

    typedef enum logic [4:0] {
        S_IDLE, S_Q_RD, S_Q_CHK, S_M_RD, S_M_CHK, S_L_RD, S_L_CHK, S_M_WR,
        S_SD_RD, S_SD_WR, S_SU_RD, S_SU_WR, S_I_RD, S_I_CHK, S_P_END, S_DONE
    } t_state;

    logic [31:0] r_mem_st [MAX_RANGES];
    logic [31:0] r_mem_en [MAX_RANGES];

    t_state         r_state;
    t_mode          r_mode;
    logic [31:0]    r_s, r_e, r_e2, r_ns, r_me, r_rd_st, r_rd_en;
    logic           r_pend, r_cov, r_full;
    logic [CW-1:0]  r_count, r_idx, r_last, r_src, r_j;
    logic           r_o_valid, r_o_cov, r_o_full;
    logic [CW-1:0]  r_o_count;
    logic [CW-1:0]  w_dst;
    logic [CW-1:0]  w_nxt;
    logic [CW-1:0]  w_prv;
    logic           w_may_fill;

    assign w_dst = r_src - r_last + r_idx;
    assign w_nxt = r_last + ONE;
    assign w_prv = r_src - ONE;
    assign w_may_fill = (r_mode == MODE_MARK) || (r_mode == MODE_INVERT);
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_o_valid;
    assign o_covered = r_o_cov;
    assign o_table_full = r_o_full;
    assign o_range_count = r_o_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_o_valid <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            if (r_o_valid && i_ready && r_state != S_DONE) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_mode <= i_mode;
                        r_cov <= 1'b1;
                        r_full <= 1'b0;
                        r_idx <= '0;
                        r_j <= '0;
                        r_e2 <= i_end_angle;
                        r_s <= (i_mode == MODE_INVERT) ? '0 : i_start_angle;
                        if (i_start_angle > i_end_angle) begin
                            r_e <= ANGLE_TOP;
                            r_pend <= 1'b1;
                        end else begin
                            r_e <= i_end_angle;
                            r_pend <= 1'b0;
                        end
                        unique case (i_mode)
                            MODE_CLEAR: begin
                                r_count <= '0;
                                r_state <= S_DONE;
                            end
                            MODE_QUERY: r_state <= S_Q_RD;
                            MODE_MARK: r_state <= S_M_RD;
                            MODE_INVERT: r_state <= S_I_RD;
                        endcase
                    end
                end
                S_Q_RD: begin
                    if (r_idx >= r_count) begin
                        r_cov <= 1'b0;
                        r_state <= S_P_END;
                    end else begin
                        r_rd_st <= r_mem_st[r_idx[AW-1:0]];
                        r_rd_en <= r_mem_en[r_idx[AW-1:0]];
                        r_state <= S_Q_CHK;
                    end
                end
                S_Q_CHK: begin
                    if (r_s >= r_rd_st && r_e <= r_rd_en) begin
                        r_state <= S_P_END;
                    end else if (r_e < r_rd_st) begin
                        r_cov <= 1'b0;
                        r_state <= S_P_END;
                    end else begin
                        r_idx <= r_idx + ONE;
                        r_state <= S_Q_RD;
                    end
                end
                S_M_RD: begin
                    if (r_idx >= r_count) begin
                        if (r_count >= MAXC) begin
                            r_full <= 1'b1;
                        end else begin
                            r_mem_st[r_count[AW-1:0]] <= r_s;
                            r_mem_en[r_count[AW-1:0]] <= r_e;
                            r_count <= r_count + ONE;
                        end
                        r_state <= S_P_END;
                    end else begin
                        r_rd_st <= r_mem_st[r_idx[AW-1:0]];
                        r_rd_en <= r_mem_en[r_idx[AW-1:0]];
                        r_state <= S_M_CHK;
                    end
                end
                S_M_CHK: begin
                    if (r_rd_st <= r_s && r_rd_en >= r_e) begin
                        r_state <= S_P_END;
                    end else if (r_rd_en >= r_s && r_rd_st <= r_e) begin
                        r_ns <= (r_s < r_rd_st) ? r_s : r_rd_st;
                        r_me <= (r_rd_en > r_e) ? r_rd_en : r_e;
                        r_last <= r_idx;
                        r_state <= S_L_RD;
                    end else if (r_rd_st > r_s) begin
                        if (r_count >= MAXC) begin
                            r_full <= 1'b1;
                            r_state <= S_P_END;
                        end else begin
                            r_src <= r_count;
                            r_state <= S_SU_RD;
                        end
                    end else begin
                        r_idx <= r_idx + ONE;
                        r_state <= S_M_RD;
                    end
                end
                S_L_RD: begin
                    if (w_nxt < r_count) begin
                        r_rd_st <= r_mem_st[w_nxt[AW-1:0]];
                        r_rd_en <= r_mem_en[w_nxt[AW-1:0]];
                        r_state <= S_L_CHK;
                    end else begin
                        r_state <= S_M_WR;
                    end
                end
                S_L_CHK: begin
                    if (r_rd_st <= r_e) begin
                        r_last <= r_last + ONE;
                        r_me <= (r_rd_en > r_e) ? r_rd_en : r_e;
                        r_state <= S_L_RD;
                    end else begin
                        r_state <= S_M_WR;
                    end
                end
                S_M_WR: begin
                    r_mem_st[r_idx[AW-1:0]] <= r_ns;
                    r_mem_en[r_idx[AW-1:0]] <= r_me;
                    r_src <= r_last + ONE;
                    r_state <= (r_last != r_idx) ? S_SD_RD : S_P_END;
                end
                S_SD_RD: begin
                    if (r_src < r_count) begin
                        r_rd_st <= r_mem_st[r_src[AW-1:0]];
                        r_rd_en <= r_mem_en[r_src[AW-1:0]];
                        r_state <= S_SD_WR;
                    end else begin
                        r_count <= r_count - r_last + r_idx;
                        r_state <= S_P_END;
                    end
                end
                S_SD_WR: begin
                    r_mem_st[w_dst[AW-1:0]] <= r_rd_st;
                    r_mem_en[w_dst[AW-1:0]] <= r_rd_en;
                    r_src <= r_src + ONE;
                    r_state <= S_SD_RD;
                end
                S_SU_RD: begin
                    if (r_src > r_idx) begin
                        r_rd_st <= r_mem_st[w_prv[AW-1:0]];
                        r_rd_en <= r_mem_en[w_prv[AW-1:0]];
                        r_state <= S_SU_WR;
                    end else begin
                        r_mem_st[r_idx[AW-1:0]] <= r_s;
                        r_mem_en[r_idx[AW-1:0]] <= r_e;
                        r_count <= r_count + ONE;
                        r_state <= S_P_END;
                    end
                end
                S_SU_WR: begin
                    r_mem_st[r_src[AW-1:0]] <= r_rd_st;
                    r_mem_en[r_src[AW-1:0]] <= r_rd_en;
                    r_src <= r_src - ONE;
                    r_state <= S_SU_RD;
                end
                S_I_RD: begin
                    if (r_idx >= r_count) begin
                        if (r_j < MAXC) begin
                            r_mem_st[r_j[AW-1:0]] <= r_s;
                            r_mem_en[r_j[AW-1:0]] <= ANGLE_TOP;
                            r_count <= r_j + ONE;
                        end else begin
                            r_full <= 1'b1;
                            r_count <= r_j;
                        end
                        r_state <= S_DONE;
                    end else begin
                        r_rd_st <= r_mem_st[r_idx[AW-1:0]];
                        r_rd_en <= r_mem_en[r_idx[AW-1:0]];
                        r_state <= S_I_CHK;
                    end
                end
                S_I_CHK: begin
                    logic [CW-1:0] v_j;
                    v_j = r_j;
                    if (r_s < r_rd_st) begin
                        if (r_j < MAXC) begin
                            r_mem_st[r_j[AW-1:0]] <= r_s;
                            r_mem_en[r_j[AW-1:0]] <= r_rd_st - 32'd1;
                            v_j = r_j + ONE;
                        end else begin
                            r_full <= 1'b1;
                        end
                    end
                    r_j <= v_j;
                    if (r_rd_en == ANGLE_TOP) begin
                        r_count <= v_j;
                        r_state <= S_DONE;
                    end else begin
                        r_s <= r_rd_en + 32'd1;
                        r_idx <= r_idx + ONE;
                        r_state <= S_I_RD;
                    end
                end
                S_P_END: begin
                    if (r_pend) begin
                        r_pend <= 1'b0;
                        r_s <= '0;
                        r_e <= r_e2;
                        r_idx <= '0;
                        r_state <= (r_mode == MODE_QUERY) ? S_Q_RD : S_M_RD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_o_valid || i_ready) begin
                        r_o_valid <= 1'b1;
                        r_o_cov <= (r_mode == MODE_QUERY) && r_cov;
                        r_o_full <= r_full;
                        r_o_count <= r_count;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `AORS_ASSERT_IMPL(a_count_bound, 1'b1, r_count <= MAXC)
    `AORS_ASSERT_NEXT(a_busy_after_accept, i_valid && o_ready, !o_ready)
    `AORS_ASSERT_IMPL(a_full_mode, o_valid && o_table_full, w_may_fill || !o_ready)
    `AORS_ASSERT_IMPL(a_cov_bound, o_valid && o_covered, o_range_count != '0)
endmodule
